@@ rtl/core/dcre_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual CSR row residual engine package
// Shared types, constants and fixed-point helpers for the engine and its
// output queue.
// ----------------------------------------------------------------------------
package dcre_pkg;

    localparam int NUM_ROWS_DEF   = 1024;
    localparam int VECTOR_LEN_DEF = 1024;
    localparam int DATA_W         = 32;
    localparam int ROW_W          = 10;
    localparam int COL_W          = 10;
    localparam int FIFO_DEPTH     = 8;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NONZERO = 2'd1,
        OP_CLOSE   = 2'd2
    } opcode_t;

    typedef logic signed [DATA_W-1:0]   q16_t;
    typedef logic signed [2*DATA_W-1:0] prod_t;

    typedef struct packed {
        q16_t combined_value;
        logic row_done;
        q16_t residual_conductance;
        q16_t residual_capacitance;
        q16_t conductance_total;
        q16_t capacitance_total;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    localparam q16_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q16_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic q16_t sat_add(input q16_t a, input q16_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic q16_t sat_sub(input q16_t a, input q16_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // The product is floored to Q16.16 by an arithmetic shift, then saturated.
    function automatic q16_t qmul_scale(input prod_t p);
        logic signed [2*DATA_W-17:0] q;
        q = p[2*DATA_W-1:16];
        if (!((&q[2*DATA_W-17:DATA_W-1]) || !(|q[2*DATA_W-17:DATA_W-1]))) begin
            return q[2*DATA_W-17] ? Q_MIN : Q_MAX;
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/core/dual_csr_row_residual_engine.sv @@
// ----------------------------------------------------------------------------
// Dual CSR row residual engine
// Streams CSR nonzeros holding conductance/capacitance pairs, accumulates
// both row products against a loaded vector and emits row residuals.
// ----------------------------------------------------------------------------
// Items arrive on the in channel (in_valid/in_stall) and one result item per
// input item leaves on the out channel (out_valid/out_stall), in order.
// The alpha weight is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce.
// A result passes five pipeline stages (input register, vector read,
// multipliers, scaling, row sums with the total read) and is then written
// into the output queue. One item is accepted in every cycle while in_stall
// is low; the row sum loop and the forwarded total write-back set that rate.
// Results wait in an eight-entry queue when the receiver stalls; in_stall
// rises once eight items are outstanding, so nothing is lost.
// After reset the row total stores are cleared one row a cycle; in_stall is
// held high until every row has been cleared. The vector store is not
// cleared; read only elements that have been loaded.
// ----------------------------------------------------------------------------
module dual_csr_row_residual_engine #(
    parameter int NUM_ROWS   = dcre_pkg::NUM_ROWS_DEF,
    parameter int VECTOR_LEN = dcre_pkg::VECTOR_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [31:0]                cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [9:0]                 row,
    input  logic [9:0]                 column,
    input  logic signed [31:0]         vector_value,
    input  logic signed [31:0]         conductance,
    input  logic signed [31:0]         capacitance,
    input  logic                       last_in_row,
    input  logic signed [31:0]         rhs_conductance,
    input  logic signed [31:0]         rhs_capacitance,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         combined_value,
    output logic                       row_done,
    output logic signed [31:0]         residual_conductance,
    output logic signed [31:0]         residual_capacitance,
    output logic signed [31:0]         conductance_total,
    output logic signed [31:0]         capacitance_total
);

    localparam int RA    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int VA    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int RXW   = (RA > dcre_pkg::ROW_W) ? RA : dcre_pkg::ROW_W;
    localparam int VXW   = (VA > dcre_pkg::COL_W) ? VA : dcre_pkg::COL_W;
    localparam int CNT_W = $clog2(dcre_pkg::FIFO_DEPTH + 1);

    dcre_pkg::q16_t       alpha_reg;
    logic                 clear_active_reg;
    logic [RA-1:0]        clear_addr_reg;
    logic [CNT_W-1:0]     credit_reg;
    logic [CNT_W-1:0]     credit_next;
    logic                 accept;
    logic                 pop;

    logic [RXW-1:0]       row_ext;
    logic [VXW-1:0]       col_ext;

    // Stage 1: input register, vector store access.
    logic                 s1_valid_reg;
    dcre_pkg::opcode_t    s1_op_reg;
    logic [RA-1:0]        s1_row_addr_reg;
    logic                 s1_row_ok_reg;
    logic [VA-1:0]        s1_col_addr_reg;
    logic                 s1_col_ok_reg;
    dcre_pkg::q16_t       s1_vval_reg;
    dcre_pkg::q16_t       s1_cond_reg;
    dcre_pkg::q16_t       s1_cap_reg;
    logic                 s1_last_reg;
    dcre_pkg::q16_t       s1_rhs_c_reg;
    dcre_pkg::q16_t       s1_rhs_k_reg;
    logic                 vec_we;

    dcre_pkg::q16_t       vec_mem [VECTOR_LEN];
    dcre_pkg::q16_t       vec_rd_reg;

    // Stage 2: multipliers.
    logic                 s2_valid_reg;
    dcre_pkg::opcode_t    s2_op_reg;
    logic [RA-1:0]        s2_row_addr_reg;
    logic                 s2_row_ok_reg;
    logic                 s2_col_ok_reg;
    dcre_pkg::q16_t       s2_cond_reg;
    dcre_pkg::q16_t       s2_cap_reg;
    logic                 s2_last_reg;
    dcre_pkg::q16_t       s2_rhs_c_reg;
    dcre_pkg::q16_t       s2_rhs_k_reg;
    dcre_pkg::q16_t       s2_x;
    dcre_pkg::prod_t      prod_c_next;
    dcre_pkg::prod_t      prod_k_next;
    dcre_pkg::prod_t      prod_a_next;

    // Stage 3: product scaling.
    logic                 s3_valid_reg;
    dcre_pkg::opcode_t    s3_op_reg;
    logic [RA-1:0]        s3_row_addr_reg;
    logic                 s3_row_ok_reg;
    dcre_pkg::q16_t       s3_cond_reg;
    logic                 s3_last_reg;
    dcre_pkg::q16_t       s3_rhs_c_reg;
    dcre_pkg::q16_t       s3_rhs_k_reg;
    dcre_pkg::prod_t      s3_prod_c_reg;
    dcre_pkg::prod_t      s3_prod_k_reg;
    dcre_pkg::prod_t      s3_prod_a_reg;

    // Stage 4: row sums, total store read.
    logic                 s4_valid_reg;
    dcre_pkg::opcode_t    s4_op_reg;
    logic [RA-1:0]        s4_row_addr_reg;
    logic                 s4_row_ok_reg;
    dcre_pkg::q16_t       s4_cond_reg;
    logic                 s4_last_reg;
    dcre_pkg::q16_t       s4_rhs_c_reg;
    dcre_pkg::q16_t       s4_rhs_k_reg;
    dcre_pkg::q16_t       s4_q_c_reg;
    dcre_pkg::q16_t       s4_q_k_reg;
    dcre_pkg::q16_t       s4_q_a_reg;
    logic                 s4_is_nz;
    logic                 s4_close;
    dcre_pkg::q16_t       sum_c_next;
    dcre_pkg::q16_t       sum_k_next;
    dcre_pkg::q16_t       combined_next;
    dcre_pkg::q16_t       row_sum_c_reg;
    dcre_pkg::q16_t       row_sum_k_reg;

    dcre_pkg::q16_t       cond_mem [NUM_ROWS];
    dcre_pkg::q16_t       cap_mem [NUM_ROWS];
    dcre_pkg::q16_t       tot_c_rd_reg;
    dcre_pkg::q16_t       tot_k_rd_reg;

    // Stage 5: totals, residuals, write-back.
    logic                 s5_valid_reg;
    logic                 s5_done_reg;
    logic [RA-1:0]        s5_row_addr_reg;
    logic                 s5_row_ok_reg;
    dcre_pkg::q16_t       s5_sum_c_reg;
    dcre_pkg::q16_t       s5_sum_k_reg;
    dcre_pkg::q16_t       s5_combined_reg;
    dcre_pkg::q16_t       s5_rhs_c_reg;
    dcre_pkg::q16_t       s5_rhs_k_reg;
    dcre_pkg::q16_t       base_c;
    dcre_pkg::q16_t       base_k;
    dcre_pkg::q16_t       tot_c_new;
    dcre_pkg::q16_t       tot_k_new;
    logic                 tot_we;

    logic                 fw_valid_reg;
    logic [RA-1:0]        fw_addr_reg;
    dcre_pkg::q16_t       fw_c_reg;
    dcre_pkg::q16_t       fw_k_reg;

    dcre_pkg::result_t    result;
    dcre_pkg::result_t    head;
    dcre_pkg::fifo_ctrl_t fifo_ctrl;
    logic                 fifo_not_empty;

    assign in_stall = clear_active_reg || (credit_reg == CNT_W'(dcre_pkg::FIFO_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign pop      = fifo_not_empty && !out_stall;
    assign row_ext  = RXW'(row);
    assign col_ext  = VXW'(column);

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop) begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!accept && pop) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            alpha_reg        <= '0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            credit_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            row_sum_c_reg    <= '0;
            row_sum_k_reg    <= '0;
            fw_valid_reg     <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                alpha_reg <= cfg_wr_data;
            end
            if (clear_active_reg) begin
                if (clear_addr_reg == RA'(NUM_ROWS - 1)) begin
                    clear_active_reg <= 1'b0;
                end
                else begin
                    clear_addr_reg <= clear_addr_reg + 1'b1;
                end
            end
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            if (s4_valid_reg && (s4_is_nz || (s4_op_reg == dcre_pkg::OP_CLOSE))) begin
                row_sum_c_reg <= s4_close ? '0 : sum_c_next;
                row_sum_k_reg <= s4_close ? '0 : sum_k_next;
            end
            fw_valid_reg <= tot_we;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg       <= dcre_pkg::opcode_t'(opcode);
        s1_row_addr_reg <= row_ext[RA-1:0];
        s1_row_ok_reg   <= (32'(row) < 32'(NUM_ROWS));
        s1_col_addr_reg <= col_ext[VA-1:0];
        s1_col_ok_reg   <= (32'(column) < 32'(VECTOR_LEN));
        s1_vval_reg     <= vector_value;
        s1_cond_reg     <= conductance;
        s1_cap_reg      <= capacitance;
        s1_last_reg     <= last_in_row;
        s1_rhs_c_reg    <= rhs_conductance;
        s1_rhs_k_reg    <= rhs_capacitance;
    end

    assign vec_we = s1_valid_reg && (s1_op_reg == dcre_pkg::OP_LOAD) && s1_col_ok_reg;

    always_ff @(posedge clk)
    begin
        if (vec_we) begin
            vec_mem[s1_col_addr_reg] <= s1_vval_reg;
        end
        vec_rd_reg <= vec_mem[s1_col_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg       <= s1_op_reg;
        s2_row_addr_reg <= s1_row_addr_reg;
        s2_row_ok_reg   <= s1_row_ok_reg;
        s2_col_ok_reg   <= s1_col_ok_reg;
        s2_cond_reg     <= s1_cond_reg;
        s2_cap_reg      <= s1_cap_reg;
        s2_last_reg     <= s1_last_reg;
        s2_rhs_c_reg    <= s1_rhs_c_reg;
        s2_rhs_k_reg    <= s1_rhs_k_reg;
    end

    always_comb
    begin
        s2_x        = s2_col_ok_reg ? vec_rd_reg : '0;
        prod_c_next = s2_cond_reg * s2_x;
        prod_k_next = s2_cap_reg * s2_x;
        prod_a_next = alpha_reg * s2_cap_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg       <= s2_op_reg;
        s3_row_addr_reg <= s2_row_addr_reg;
        s3_row_ok_reg   <= s2_row_ok_reg;
        s3_cond_reg     <= s2_cond_reg;
        s3_last_reg     <= s2_last_reg;
        s3_rhs_c_reg    <= s2_rhs_c_reg;
        s3_rhs_k_reg    <= s2_rhs_k_reg;
        s3_prod_c_reg   <= prod_c_next;
        s3_prod_k_reg   <= prod_k_next;
        s3_prod_a_reg   <= prod_a_next;
    end

    always_ff @(posedge clk)
    begin
        s4_op_reg       <= s3_op_reg;
        s4_row_addr_reg <= s3_row_addr_reg;
        s4_row_ok_reg   <= s3_row_ok_reg;
        s4_cond_reg     <= s3_cond_reg;
        s4_last_reg     <= s3_last_reg;
        s4_rhs_c_reg    <= s3_rhs_c_reg;
        s4_rhs_k_reg    <= s3_rhs_k_reg;
        s4_q_c_reg      <= dcre_pkg::qmul_scale(s3_prod_c_reg);
        s4_q_k_reg      <= dcre_pkg::qmul_scale(s3_prod_k_reg);
        s4_q_a_reg      <= dcre_pkg::qmul_scale(s3_prod_a_reg);
    end

    always_comb
    begin
        s4_is_nz      = (s4_op_reg == dcre_pkg::OP_NONZERO);
        s4_close      = (s4_is_nz && s4_last_reg) || (s4_op_reg == dcre_pkg::OP_CLOSE);
        sum_c_next    = s4_is_nz ? dcre_pkg::sat_add(row_sum_c_reg, s4_q_c_reg) : row_sum_c_reg;
        sum_k_next    = s4_is_nz ? dcre_pkg::sat_add(row_sum_k_reg, s4_q_k_reg) : row_sum_k_reg;
        combined_next = s4_is_nz ? dcre_pkg::sat_add(s4_cond_reg, s4_q_a_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        s5_done_reg     <= s4_close;
        s5_row_addr_reg <= s4_row_addr_reg;
        s5_row_ok_reg   <= s4_row_ok_reg;
        s5_sum_c_reg    <= sum_c_next;
        s5_sum_k_reg    <= sum_k_next;
        s5_combined_reg <= combined_next;
        s5_rhs_c_reg    <= s4_rhs_c_reg;
        s5_rhs_k_reg    <= s4_rhs_k_reg;
    end

    // A total written in the previous cycle is not yet in the read data.
    always_comb
    begin
        if (fw_valid_reg && (fw_addr_reg == s5_row_addr_reg)) begin
            base_c = fw_c_reg;
            base_k = fw_k_reg;
        end
        else begin
            base_c = tot_c_rd_reg;
            base_k = tot_k_rd_reg;
        end
        tot_c_new = dcre_pkg::sat_add(base_c, s5_sum_c_reg);
        tot_k_new = dcre_pkg::sat_add(base_k, s5_sum_k_reg);
        tot_we    = s5_valid_reg && s5_done_reg && s5_row_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (clear_active_reg) begin
            cond_mem[clear_addr_reg] <= '0;
            cap_mem[clear_addr_reg]  <= '0;
        end
        else if (tot_we) begin
            cond_mem[s5_row_addr_reg] <= tot_c_new;
            cap_mem[s5_row_addr_reg]  <= tot_k_new;
        end
        tot_c_rd_reg <= cond_mem[s4_row_addr_reg];
        tot_k_rd_reg <= cap_mem[s4_row_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        fw_addr_reg <= s5_row_addr_reg;
        fw_c_reg    <= tot_c_new;
        fw_k_reg    <= tot_k_new;
    end

    always_comb
    begin
        result.combined_value       = s5_combined_reg;
        result.row_done             = s5_done_reg;
        result.residual_conductance = s5_done_reg ?
                                      dcre_pkg::sat_sub(s5_rhs_c_reg, s5_sum_c_reg) : '0;
        result.residual_capacitance = s5_done_reg ?
                                      dcre_pkg::sat_sub(s5_rhs_k_reg, s5_sum_k_reg) : '0;
        result.conductance_total    = (s5_done_reg && s5_row_ok_reg) ? tot_c_new : '0;
        result.capacitance_total    = (s5_done_reg && s5_row_ok_reg) ? tot_k_new : '0;
        fifo_ctrl.push              = s5_valid_reg;
        fifo_ctrl.pop               = pop;
    end

    dcre_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_data (result),
        .head_data (head),
        .not_empty (fifo_not_empty)
    );

    assign out_valid            = fifo_not_empty;
    assign combined_value       = head.combined_value;
    assign row_done             = head.row_done;
    assign residual_conductance = head.residual_conductance;
    assign residual_capacitance = head.residual_capacitance;
    assign conductance_total    = head.conductance_total;
    assign capacitance_total    = head.capacitance_total;

endmodule

@@ rtl/core/dcre_result_fifo.sv @@
// ----------------------------------------------------------------------------
// Dual CSR row residual engine output queue
// Small first-in first-out queue that holds finished result items until the
// receiver takes them.
// ----------------------------------------------------------------------------
module dcre_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcre_pkg::fifo_ctrl_t ctrl,
    input  dcre_pkg::result_t    push_data,
    output dcre_pkg::result_t    head_data,
    output logic                 not_empty
);

    localparam int PW = (dcre_pkg::FIFO_DEPTH > 1) ? $clog2(dcre_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(dcre_pkg::FIFO_DEPTH + 1);

    dcre_pkg::result_t entry_reg [dcre_pkg::FIFO_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(dcre_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(dcre_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctrl.push && ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule
